[sv/sdps_pkg.sv]
// Shared constants, types and tables for the soft-disc particle splatter.
`timescale 1ns / 1ps
package sdps_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 16;

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int AW     = XW + YW;
  localparam int DIM_W  = 9;
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int R2W    = 9;
  localparam int CW     = 11;
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  localparam logic signed [18:0] POS_LOW  = -19'sd65536;
  localparam logic signed [18:0] POS_HIGH = 19'sd131072;

  typedef enum logic [1:0] {
    KIND_SPLAT = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_SPLAT,
    OP_CLEAR,
    OP_READ
  } cmd_op_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SPLAT,
    BK_DRAIN,
    BK_CLEAR,
    BK_READ_WAIT
  } back_state_e;

  typedef struct packed {
    cmd_op_e               op;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic [RW-1:0]         r;
    logic [R2W-1:0]        r2;
    logic [XW-1:0]         x0;
    logic [XW-1:0]         x1;
    logic [YW-1:0]         y0;
    logic [YW-1:0]         y1;
    logic [3:0][7:0]       col;
    logic                  rd_zero;
    logic [XW-1:0]         rx;
    logic [YW-1:0]         ry;
  } cmd_t;

  // ceil(2^32 / r^2); with it a product shifted right by 32 divides exactly by r^2
  // for any dividend below 2^24.
  function automatic logic [32:0] recip(input logic [RW-1:0] r);
    logic [32:0] v;
    case (r)
      5'd1:    v = 33'd4294967296;
      5'd2:    v = 33'd1073741824;
      5'd3:    v = 33'd477218589;
      5'd4:    v = 33'd268435456;
      5'd5:    v = 33'd171798692;
      5'd6:    v = 33'd119304648;
      5'd7:    v = 33'd87652394;
      5'd8:    v = 33'd67108864;
      5'd9:    v = 33'd53024288;
      5'd10:   v = 33'd42949673;
      5'd11:   v = 33'd35495598;
      5'd12:   v = 33'd29826162;
      5'd13:   v = 33'd25414008;
      5'd14:   v = 33'd21913099;
      5'd15:   v = 33'd19088744;
      5'd16:   v = 33'd16777216;
      default: v = 33'd4294967296;
    endcase
    return v;
  endfunction

endpackage

[sv/soft_disc_particle_splatter_unit.sv]
// Top level of the soft-disc particle splatter: configuration registers and wiring.
`timescale 1ns / 1ps
// The block keeps a 256 x 256 RGBA8 premultiplied frame store. Items arrive on the
// in_valid_i/in_ready_o channel: a splat adds a soft disc around the particle centre,
// a clear zeroes the store, and a read returns one pixel on the out_valid_o/out_ready_i
// channel. Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) set the active frame
// width and height and take effect at once; the user must see that they are made only
// while the block is idle, which the block itself does not enforce. The front end takes
// no new beat until it has passed the last into a four-entry command queue or dropped
// it. The back end walks a splat's clipped square at one pixel a cycle through a
// seven-stage read-modify-write pipeline on the frame store, which has one read and one
// write port. A clear sweeps the store one entry a cycle; after reset the same sweep
// runs, with in_ready_o low throughout. A read that finds the back end idle passes the
// front-end register, the queue, the read register and the output register. A stalled
// result waits in the output register; the queue keeps taking items until a further
// read reaches its head, which then blocks the queue until the waiting beat is taken.
module soft_disc_particle_splatter_unit import sdps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [DIM_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic signed [18:0] pos_x_i,
  input  logic signed [18:0] pos_y_i,
  input  logic [15:0]        size_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         alpha_i,
  input  logic [7:0]         read_x_i,
  input  logic [7:0]         read_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         pixel_red_o,
  output logic [7:0]         pixel_green_o,
  output logic [7:0]         pixel_blue_o,
  output logic [7:0]         pixel_alpha_o
);

  logic [DIM_W-1:0] width_q, height_q, w_eff, h_eff;
  logic             q_push, q_full, q_pop, q_valid, init_busy;
  cmd_t             q_in, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(MAX_WIDTH);
      height_q <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A size of zero acts as one; anything beyond the store acts as its full size.
  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_q > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  sdps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .size_i     (size_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .alpha_i    (alpha_i),
    .read_x_i   (read_x_i),
    .read_y_i   (read_y_i),
    .frame_w_i  (w_eff),
    .frame_h_i  (h_eff),
    .hold_i     (init_busy),
    .push_o     (q_push),
    .cmd_o      (q_in),
    .full_i     (q_full)
  );

  sdps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  sdps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_head),
    .pop_o         (q_pop),
    .init_busy_o   (init_busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_red_o   (pixel_red_o),
    .pixel_green_o (pixel_green_o),
    .pixel_blue_o  (pixel_blue_o),
    .pixel_alpha_o (pixel_alpha_o)
  );

  a_push_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_pop_has_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("command popped from an empty queue");

  a_no_accept_in_init : assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !in_ready_o)
    else $error("item accepted during the reset clearing sweep");

endmodule

[sv/sdps_front.sv]
// Front end: accepts items, scales the particle and queues a command for the back end.
`timescale 1ns / 1ps
module sdps_front import sdps_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              kind_i,
  input  logic signed [18:0]      pos_x_i,
  input  logic signed [18:0]      pos_y_i,
  input  logic [15:0]             size_i,
  input  logic [7:0]              red_i,
  input  logic [7:0]              green_i,
  input  logic [7:0]              blue_i,
  input  logic [7:0]              alpha_i,
  input  logic [7:0]              read_x_i,
  input  logic [7:0]              read_y_i,
  input  logic [DIM_W-1:0]        frame_w_i,
  input  logic [DIM_W-1:0]        frame_h_i,
  input  logic                    hold_i,
  output logic                    push_o,
  output cmd_t                    cmd_o,
  input  logic                    full_i
);

  logic                 a_valid_q;
  logic [1:0]           a_kind_q;
  logic signed [28:0]   a_px_q, a_py_q;
  logic [24:0]          a_rs_q;
  logic [2:0][15:0]     a_prod_q;
  logic [7:0]           a_alpha_q;
  logic                 a_skip_q;
  logic [7:0]           a_rx_q, a_ry_q;
  logic                 a_rdz_q;

  logic                 accept;
  logic signed [28:0]   px_prod, py_prod;
  logic                 skip;

  assign in_ready_o = !a_valid_q && !hold_i;
  assign accept     = in_valid_i && in_ready_o;

  assign px_prod = pos_x_i * $signed({1'b0, frame_w_i});
  assign py_prod = pos_y_i * $signed({1'b0, frame_h_i});
  assign skip    = (alpha_i == 8'd0) || (pos_x_i < POS_LOW) || (pos_x_i > POS_HIGH) ||
                   (pos_y_i < POS_LOW) || (pos_y_i > POS_HIGH);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_kind_q    <= kind_i;
      a_px_q      <= px_prod;
      a_py_q      <= py_prod;
      a_rs_q      <= {9'd0, size_i} * {16'd0, frame_w_i};
      a_prod_q[0] <= {8'd0, red_i} * {8'd0, alpha_i};
      a_prod_q[1] <= {8'd0, green_i} * {8'd0, alpha_i};
      a_prod_q[2] <= {8'd0, blue_i} * {8'd0, alpha_i};
      a_alpha_q   <= alpha_i;
      a_skip_q    <= skip;
      a_rx_q      <= read_x_i;
      a_ry_q      <= read_y_i;
      a_rdz_q     <= ({1'b0, read_x_i} >= frame_w_i) || ({1'b0, read_y_i} >= frame_h_i);
    end
  end

  // Second step: centre, radius, clipped square and premultiplied colour.
  logic [28:0]          px_mag, py_mag;
  logic signed [11:0]   cx_w, cy_w, rs, wmax, hmax;
  logic signed [11:0]   xlo, xhi, ylo, yhi, x0, x1, y0, y1;
  logic [8:0]           r_raw;
  logic [RW-1:0]        r;
  logic [2*RW-1:0]      r_sq;
  logic [2:0][15:0]     csum;
  logic                 keep;

  always_comb begin
    px_mag = a_px_q[28] ? 29'(-a_px_q) : 29'(a_px_q);
    py_mag = a_py_q[28] ? 29'(-a_py_q) : 29'(a_py_q);
    // Truncation toward zero: divide the magnitude, then restore the sign.
    cx_w = a_px_q[28] ? -$signed({1'b0, px_mag[26:16]}) : $signed({1'b0, px_mag[26:16]});
    cy_w = a_py_q[28] ? -$signed({1'b0, py_mag[26:16]}) : $signed({1'b0, py_mag[26:16]});
    r_raw = a_rs_q[24:16];
    if (r_raw == 9'd0) begin
      r = RW'(1);
    end else if (r_raw > 9'(MAX_RADIUS)) begin
      r = RW'(MAX_RADIUS);
    end else begin
      r = r_raw[RW-1:0];
    end
    r_sq = {{RW{1'b0}}, r} * {{RW{1'b0}}, r};
    rs   = $signed({{(12-RW){1'b0}}, r});
    wmax = $signed({3'd0, frame_w_i}) - 12'sd1;
    hmax = $signed({3'd0, frame_h_i}) - 12'sd1;
    xlo  = cx_w - rs;
    xhi  = cx_w + rs;
    ylo  = cy_w - rs;
    yhi  = cy_w + rs;
    x0   = (xlo < 12'sd0) ? 12'sd0 : xlo;
    x1   = (xhi > wmax) ? wmax : xhi;
    y0   = (ylo < 12'sd0) ? 12'sd0 : ylo;
    y1   = (yhi > hmax) ? hmax : yhi;
    for (int k = 0; k < 3; k++) begin
      // Exact division by 255 for any product of two bytes.
      csum[k] = a_prod_q[k] + {8'd0, a_prod_q[k][15:8]} + 16'd1;
    end

    case (kind_e'(a_kind_q))
      KIND_SPLAT: keep = !a_skip_q && (x0 <= x1) && (y0 <= y1);
      KIND_CLEAR: keep = 1'b1;
      KIND_READ:  keep = 1'b1;
      default:    keep = 1'b0;
    endcase

    case (kind_e'(a_kind_q))
      KIND_CLEAR: cmd_o.op = OP_CLEAR;
      KIND_READ:  cmd_o.op = OP_READ;
      default:    cmd_o.op = OP_SPLAT;
    endcase
    cmd_o.cx      = cx_w[CW-1:0];
    cmd_o.cy      = cy_w[CW-1:0];
    cmd_o.r       = r;
    cmd_o.r2      = r_sq[R2W-1:0];
    cmd_o.x0      = x0[XW-1:0];
    cmd_o.x1      = x1[XW-1:0];
    cmd_o.y0      = y0[YW-1:0];
    cmd_o.y1      = y1[YW-1:0];
    cmd_o.col[0]  = csum[0][15:8];
    cmd_o.col[1]  = csum[1][15:8];
    cmd_o.col[2]  = csum[2][15:8];
    cmd_o.col[3]  = a_alpha_q;
    cmd_o.rd_zero = a_rdz_q;
    cmd_o.rx      = a_rx_q[XW-1:0];
    cmd_o.ry      = a_ry_q[YW-1:0];
  end

  assign push_o = a_valid_q && keep && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (a_valid_q && (!keep || !full_i)) begin
      a_valid_q <= 1'b0;
    end
  end

endmodule

[sv/sdps_queue.sv]
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module sdps_queue import sdps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t           slot_q [QDEPTH];
  logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPW:0]   count_q;

  assign full_o  = (count_q == (QPW+1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[sv/sdps_back.sv]
// Back end: frame store, clearing sweep, splat walker with its pixel pipeline, reads.
`timescale 1ns / 1ps
module sdps_back import sdps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       init_busy_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] pixel_red_o,
  output logic [7:0] pixel_green_o,
  output logic [7:0] pixel_blue_o,
  output logic [7:0] pixel_alpha_o
);

  back_state_e state_q, state_d;
  logic        init_q;
  logic [AW-1:0] clr_q;

  // Splat command held during the walk.
  logic signed [CW-1:0] cx_q, cy_q;
  logic [R2W-1:0]       r2_q;
  logic [XW-1:0]        x0_q, x1_q, wx_q;
  logic [YW-1:0]        y1_q, wy_q;
  logic [3:0][7:0]      col_q;
  logic [32:0]          rcp_q;

  logic issue, load_cmd, clr_we, clr_done, rd_launch, out_load, last_px;
  logic rdz_q;
  logic out_valid_q;
  logic [3:0][7:0] pix_q;

  // Pixel pipeline, one stage per register.
  logic [7:1]          v_q;
  logic [8:0]          dx2_q, dy2_q;
  logic [AW-1:0]       a1_q, a2_q, a3_q, a4_q, a5_q, a6_q, a7_q;
  logic [R2W-1:0]      t_q;
  logic [16:0]         tsq_q;
  logic [3:0][23:0]    n_q, q1_q;
  logic [3:0][7:0]     q2_q, q3_q;

  logic [31:0]         frame_q [MAX_WIDTH*MAX_HEIGHT];
  logic [31:0]         rdata_q, wdata;
  logic [AW-1:0]       raddr, waddr;
  logic                we;

  assign last_px = (wx_q == x1_q) && (wy_q == y1_q);

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    issue     = 1'b0;
    load_cmd  = 1'b0;
    clr_we    = 1'b0;
    clr_done  = 1'b0;
    rd_launch = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_SPLAT: begin
              pop_o    = 1'b1;
              load_cmd = 1'b1;
              state_d  = BK_SPLAT;
            end
            OP_CLEAR: begin
              pop_o   = 1'b1;
              state_d = BK_CLEAR;
            end
            OP_READ: begin
              if (!out_valid_q) begin
                pop_o     = 1'b1;
                rd_launch = 1'b1;
                state_d   = BK_READ_WAIT;
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      BK_SPLAT: begin
        issue = 1'b1;
        if (last_px) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (v_q == '0) begin
          state_d = BK_IDLE;
        end
      end
      BK_CLEAR: begin
        clr_we = 1'b1;
        if (clr_q == {AW{1'b1}}) begin
          clr_done = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      BK_READ_WAIT: begin
        out_load = 1'b1;
        state_d  = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      init_q      <= 1'b1;
      clr_q       <= '0;
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_we) begin
        clr_q <= clr_q + 1'b1;
      end
      if (clr_done) begin
        init_q <= 1'b0;
      end
      v_q[1] <= issue;
      v_q[2] <= v_q[1] && ({1'b0, dx2_q} + {1'b0, dy2_q} < {1'b0, r2_q});
      v_q[7:3] <= v_q[6:2];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cmd) begin
      cx_q  <= cmd_i.cx;
      cy_q  <= cmd_i.cy;
      r2_q  <= cmd_i.r2;
      x0_q  <= cmd_i.x0;
      x1_q  <= cmd_i.x1;
      y1_q  <= cmd_i.y1;
      col_q <= cmd_i.col;
      rcp_q <= recip(cmd_i.r);
      wx_q  <= cmd_i.x0;
      wy_q  <= cmd_i.y0;
    end else if (issue) begin
      if (wx_q == x1_q) begin
        wx_q <= x0_q;
        wy_q <= wy_q + 1'b1;
      end else begin
        wx_q <= wx_q + 1'b1;
      end
    end
    if (rd_launch) begin
      rdz_q <= cmd_i.rd_zero;
    end
    if (out_load) begin
      pix_q <= rdz_q ? '0 : rdata_q;
    end
  end

  // Offsets from the centre stay within the radius, so six signed bits hold them.
  logic signed [11:0] dx, dy;
  logic signed [5:0]  dxn, dyn;
  logic signed [11:0] dxsq, dysq;
  logic [9:0]         d2;
  logic [17:0]        tsq_w;

  always_comb begin
    dx    = $signed({{(12-XW){1'b0}}, wx_q}) - $signed({cx_q[CW-1], cx_q});
    dy    = $signed({{(12-YW){1'b0}}, wy_q}) - $signed({cy_q[CW-1], cy_q});
    dxn   = dx[5:0];
    dyn   = dy[5:0];
    dxsq  = dxn * dxn;
    dysq  = dyn * dyn;
    d2    = {1'b0, dx2_q} + {1'b0, dy2_q};
    tsq_w = {9'd0, t_q} * {9'd0, t_q};
  end

  always_ff @(posedge clk_i) begin
    dx2_q <= dxsq[8:0];
    dy2_q <= dysq[8:0];
    a1_q  <= {wy_q, wx_q};
    t_q   <= r2_q - d2[8:0];
    a2_q  <= a1_q;
    tsq_q <= tsq_w[16:0];
    a3_q  <= a2_q;
    a4_q  <= a3_q;
    a5_q  <= a4_q;
    a6_q  <= a5_q;
    a7_q  <= a6_q;
    for (int k = 0; k < 4; k++) begin
      n_q[k]  <= 24'({16'd0, col_q[k]} * {7'd0, tsq_q});
      q1_q[k] <= 24'(57'({33'd0, n_q[k]} * {24'd0, rcp_q}) >> 32);
      q2_q[k] <= 8'(57'({33'd0, q1_q[k]} * {24'd0, rcp_q}) >> 32);
      q3_q[k] <= q2_q[k];
    end
  end

  // Frame store: read data registered, written by the sweep or the last pipeline stage.
  logic [3:0][8:0] acc;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc[k] = {1'b0, rdata_q[8*k +: 8]} + {1'b0, q3_q[k]};
      wdata[8*k +: 8] = acc[k][8] ? 8'hFF : acc[k][7:0];
    end
    if (clr_we) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else begin
      we    = v_q[7];
      waddr = a7_q;
    end
    raddr = rd_launch ? {cmd_i.ry, cmd_i.rx} : a6_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      frame_q[waddr] <= wdata;
    end
    rdata_q <= frame_q[raddr];
  end

  assign init_busy_o   = init_q;
  assign out_valid_o   = out_valid_q;
  assign pixel_red_o   = pix_q[0];
  assign pixel_green_o = pix_q[1];
  assign pixel_blue_o  = pix_q[2];
  assign pixel_alpha_o = pix_q[3];

endmodule

[verif/sdps_checker.sv]
// Scoreboard for the soft-disc splatter: predicts read beats from a frame store copy.
`timescale 1ns / 1ps
module sdps_checker import sdps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [DIM_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         kind_i,
  input  logic signed [18:0] pos_x_i,
  input  logic signed [18:0] pos_y_i,
  input  logic [15:0]        size_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         alpha_i,
  input  logic [7:0]         read_x_i,
  input  logic [7:0]         read_y_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [7:0]         pixel_red_i,
  input  logic [7:0]         pixel_green_i,
  input  logic [7:0]         pixel_blue_i,
  input  logic [7:0]         pixel_alpha_i,
  output int                 fails_o,
  output int                 pending_o
);

  // Each entry holds {alpha, blue, green, red}.
  logic [3:0][7:0] frame_copy [MAX_WIDTH*MAX_HEIGHT];
  logic [3:0][7:0] pixels_due [$];
  logic [DIM_W-1:0] width_reg  = 9'd256;
  logic [DIM_W-1:0] height_reg = 9'd256;

  assign pending_o = pixels_due.size();

  initial begin
    fails_o = 0;
    foreach (frame_copy[i]) frame_copy[i] = '0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fails_o++;
  endtask

  function automatic int active_dim(input logic [DIM_W-1:0] v, input int lim);
    if (v == 0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic void add_disc(input logic signed [18:0] px, input logic signed [18:0] py,
                                   input logic [15:0] sz, input logic [7:0] rd,
                                   input logic [7:0] gr, input logic [7:0] bl,
                                   input logic [7:0] al);
    int w, h, r, r2, dx, dy, d2, xa, xb, ya, yb;
    longint cx, cy, den, t, s;
    longint tint [4];
    w = active_dim(width_reg, MAX_WIDTH);
    h = active_dim(height_reg, MAX_HEIGHT);
    if (al == 0) return;
    if (px < POS_LOW || px > POS_HIGH || py < POS_LOW || py > POS_HIGH) return;
    // Signed division truncates toward zero, as the centre needs.
    cx = (longint'(px) * w) / 65536;
    cy = (longint'(py) * h) / 65536;
    r = int'((longint'(sz) * w) >> 16);
    if (r < 1) r = 1;
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    r2  = r * r;
    den = longint'(r2) * r2;
    tint[0] = (longint'(rd) * al) / 255;
    tint[1] = (longint'(gr) * al) / 255;
    tint[2] = (longint'(bl) * al) / 255;
    tint[3] = al;
    xa = (cx - r < 0) ? 0 : int'(cx - r);
    xb = (cx + r > w - 1) ? w - 1 : int'(cx + r);
    ya = (cy - r < 0) ? 0 : int'(cy - r);
    yb = (cy + r > h - 1) ? h - 1 : int'(cy + r);
    for (int y = ya; y <= yb; y++) begin
      dy = y - int'(cy);
      for (int x = xa; x <= xb; x++) begin
        dx = x - int'(cx);
        d2 = dx * dx + dy * dy;
        if (d2 < r2) begin
          t = r2 - d2;
          for (int k = 0; k < 4; k++) begin
            s = frame_copy[y*MAX_WIDTH+x][k] + (tint[k] * t * t) / den;
            frame_copy[y*MAX_WIDTH+x][k] = (s > 255) ? 8'd255 : 8'(s);
          end
        end
      end
    end
  endfunction

  always @(posedge clk_i) begin
    logic [3:0][7:0] want;
    logic [3:0][7:0] got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_reg_e'(cfg_idx_i) == REG_FRAME_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        case (kind_i)
          KIND_SPLAT: add_disc(pos_x_i, pos_y_i, size_i, red_i, green_i, blue_i, alpha_i);
          KIND_CLEAR: foreach (frame_copy[i]) frame_copy[i] = '0;
          KIND_READ: begin
            if (int'(read_x_i) >= active_dim(width_reg, MAX_WIDTH) ||
                int'(read_y_i) >= active_dim(height_reg, MAX_HEIGHT))
              pixels_due.push_back('0);
            else
              pixels_due.push_back(frame_copy[int'(read_y_i)*MAX_WIDTH+int'(read_x_i)]);
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = {pixel_alpha_i, pixel_blue_i, pixel_green_i, pixel_red_i};
        if (pixels_due.size() == 0) begin
          report_mismatch("read beat with no read outstanding");
        end else begin
          want = pixels_due.pop_front();
          for (int k = 0; k < 4; k++)
            if (got[k] != want[k])
              report_mismatch($sformatf("channel %0d got %0d expected %0d",
                                        k, got[k], want[k]));
        end
      end
    end
  end

endmodule

[verif/tb_soft_disc_particle_splatter_unit.sv]
// Stimulus, clocking and verdict for the soft-disc particle splatter regression.
`timescale 1ns / 1ps
module tb_soft_disc_particle_splatter_unit import sdps_pkg::*;;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 300000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [DIM_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] kind_i = '0;
  logic signed [18:0] pos_x_i = '0;
  logic signed [18:0] pos_y_i = '0;
  logic [15:0] size_i = '0;
  logic [7:0] red_i = '0, green_i = '0, blue_i = '0, alpha_i = '0;
  logic [7:0] read_x_i = '0, read_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] pixel_red_o, pixel_green_o, pixel_blue_o, pixel_alpha_o;
  int fails, pending;

  bit calm = 0;
  bit hold_wanted = 0;
  int cur_w = 256, cur_h = 256;
  int last_cx = 128, last_cy = 128;
  int clears_left = 3;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  soft_disc_particle_splatter_unit dut (.*);

  sdps_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .pos_x_i, .pos_y_i, .size_i,
    .red_i, .green_i, .blue_i, .alpha_i, .read_x_i, .read_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .pixel_red_i(pixel_red_o),
    .pixel_green_i(pixel_green_o), .pixel_blue_i(pixel_blue_o),
    .pixel_alpha_i(pixel_alpha_o), .fails_o(fails), .pending_o(pending)
  );

  // Result side: random back-pressure, plus one long hold-off when asked for.
  always @(posedge clk_i) begin
    int hold_left;
    bit hold_done;
    if (hold_wanted && !hold_done) begin
      hold_left = 3000;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk_i) begin
    int quiet;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("soft_disc_particle_splatter_unit regression: fail");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] k, input logic signed [18:0] px,
                           input logic signed [18:0] py, input logic [15:0] sz,
                           input logic [7:0] rd, input logic [7:0] gr, input logic [7:0] bl,
                           input logic [7:0] al, input logic [7:0] rx, input logic [7:0] ry);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k; pos_x_i <= px; pos_y_i <= py; size_i <= sz;
    red_i <= rd; green_i <= gr; blue_i <= bl; alpha_i <= al;
    read_x_i <= rx; read_y_i <= ry;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic read_px(input int x, input int y);
    send_beat(KIND_READ, 19'($urandom), 19'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom), 8'(x), 8'(y));
  endtask

  // A read drains behind everything before it, so its return marks the block idle.
  task automatic settle();
    read_px($urandom_range(255), $urandom_range(255));
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= REG_FRAME_WIDTH; cfg_data_i <= 9'(w);
    @(posedge clk_i);
    cfg_idx_i <= REG_FRAME_HEIGHT; cfg_data_i <= 9'(h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0; cfg_data_i <= 9'($urandom);
    cur_w = (w == 0) ? 1 : (w > 256 ? 256 : w);
    cur_h = (h == 0) ? 1 : (h > 256 ? 256 : h);
  endtask

  task automatic rand_splat();
    logic signed [18:0] px, py;
    logic [15:0] sz;
    if ($urandom_range(9) == 0) begin
      px = 19'($urandom); py = 19'($urandom);
    end else begin
      px = 19'($signed($urandom_range(0, 196608)) - 65536);
      py = 19'($signed($urandom_range(0, 196608)) - 65536);
      if ($urandom_range(2) == 0) begin
        px = 19'($urandom_range(0, 65535)); py = 19'($urandom_range(0, 65535));
      end
    end
    // Mostly modest radii keep the walk short; now and then the full clamp.
    if ($urandom_range(9) == 0) sz = 16'($urandom);
    else sz = 16'($urandom_range(0, 65536 * 9 / cur_w));
    last_cx = (int'(px) * cur_w) / 65536;
    last_cy = (int'(py) * cur_h) / 65536;
    send_beat(KIND_SPLAT, px, py, sz, 8'($urandom), 8'($urandom), 8'($urandom),
              ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  task automatic rand_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 48) rand_splat();
    else if (pick < 96) begin
      if ($urandom_range(4) == 0) read_px($urandom_range(255), $urandom_range(255));
      else read_px((last_cx + $urandom_range(0, 12) - 6) & 255,
                   (last_cy + $urandom_range(0, 12) - 6) & 255);
    end else if (pick < 98 && clears_left > 0) begin
      clears_left--;
      send_beat(KIND_CLEAR, 19'($urandom), 19'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      send_beat(KIND_UNUSED, 19'($urandom), 19'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int widths [5] = '{256, 0, 17, 300, 40};
    int heights [5] = '{256, 511, 3, 200, 40};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: full-radius disc, saturation, skipped splats, extremes, unused kind, clear, small frame.
    send_beat(KIND_SPLAT, 19'sd32768, 19'sd32768, 16'hFFFF, 8'd255, 8'd128, 8'd0,
              8'd255, 8'd0, 8'd0);
    read_px(128, 128); read_px(140, 128); read_px(128, 143);
    send_beat(KIND_SPLAT, 19'sd32768, 19'sd32768, 16'd1024, 8'd255, 8'd255, 8'd255,
              8'd255, 8'd0, 8'd0);
    read_px(128, 128);
    send_beat(KIND_SPLAT, 19'sd0, 19'sd0, 16'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    send_beat(KIND_SPLAT, -19'sd65537, 19'sd0, 16'd2000, 8'd9, 8'd9, 8'd9, 8'd99, 8'd0, 8'd0);
    send_beat(KIND_SPLAT, 19'sd0, 19'sd131073, 16'd2000, 8'd9, 8'd9, 8'd9, 8'd99, 8'd0, 8'd0);
    send_beat(KIND_SPLAT, -19'sd65536, 19'sd131072, 16'd3000, 8'd200, 8'd1, 8'd77,
              8'd1, 8'd0, 8'd0);
    send_beat(KIND_SPLAT, -19'sd300, 19'sd65535, 16'd3000, 8'd255, 8'd255, 8'd255,
              8'd200, 8'd0, 8'd0);
    read_px(0, 255); read_px(0, 0); read_px(255, 255);
    send_beat(KIND_UNUSED, 19'sd5, 19'sd5, 16'd9, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0);
    send_beat(KIND_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    read_px(128, 128);
    settle();
    set_frame(100, 80);
    send_beat(KIND_SPLAT, 19'sd65535, 19'sd65535, 16'd5000, 8'd10, 8'd20, 8'd30,
              8'd255, 8'd0, 8'd0);
    read_px(99, 79); read_px(100, 10); read_px(10, 200); read_px(97, 78);
    settle();

    // Random phases, each under its own frame size; the store carries over.
    for (int ph = 0; ph < 5; ph++) begin
      set_frame(widths[ph], heights[ph]);
      for (int n = 0; n < 110; n++) begin
        calm = (ph == 1 && n >= 20 && n < 90);
        if (ph == 2 && n == 30) hold_wanted = 1;
        rand_item();
      end
      calm = 0;
      settle();
    end

    repeat (20) @(posedge clk_i);
    if (fails == 0) $display("soft_disc_particle_splatter_unit regression: pass");
    else $display("soft_disc_particle_splatter_unit regression: fail");
    $finish;
  end

endmodule
